### rtl/core/idc_pkg.sv
package idc_pkg;

    // counter width of the session byte count
    localparam int COUNT_BITS = 24;
    localparam int DELAY_BITS = 10;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [DELAY_BITS-1:0] DELAY_RESET = DELAY_BITS'(200);

    // command codes
    typedef enum logic [2:0] {
        FN_BEGIN = 3'd0,
        FN_DATA  = 3'd1,
        FN_END   = 3'd2,
        FN_ABORT = 3'd3,
        FN_TICK  = 3'd4
    } t_func;

    // session status
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_BUSY = 2'd1,
        ST_DONE = 2'd2,
        ST_FAIL = 2'd3
    } t_status;

    // error codes
    typedef enum logic [3:0] {
        E_NONE       = 4'd0,
        E_ACTIVE     = 4'd1,
        E_BADSIZE    = 4'd2,
        E_FLASH      = 4'd3,
        E_NOTSTARTED = 4'd4,
        E_NOTACTIVE  = 4'd5,
        E_SIZE       = 4'd6,
        E_CRC        = 4'd7,
        E_ABORTED    = 4'd8
    } t_err;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_EXP_SIZE = 2'd0,
        CFG_EXP_CRC  = 2'd1,
        CFG_DELAY    = 2'd2
    } t_cfg_idx;

    // input word
    typedef struct packed {
        logic [2:0] func;
        logic [7:0] data_byte;
        logic       flash_ok;
        logic       reboot_after;
    } t_in_word;

    // result word
    typedef struct packed {
        logic                  ok;
        logic                  accepted;
        logic [1:0]            status;
        logic [3:0]            last_error;
        logic [COUNT_BITS-1:0] bytes_written;
        logic [31:0]           crc_value;
        logic                  reboot_request;
    } t_out_word;

    // one byte of reflected crc-32 with pre and post inversion
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = ~crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = CRC_POLY ^ (c >> 1);
            end else begin
                c = c >> 1;
            end
        end
        return ~c;
    endfunction

endpackage

### rtl/core/image_download_checker.sv
// firmware image receiver with crc-32 check
// input channel: i_in_valid / o_in_stall carry one command word (begin, data
//   byte, end, abort, millisecond tick) with the byte and the flash result
// output channel: o_out_valid / i_out_stall return one result word per
//   command: ok, accepted, status, last error, byte count, crc, reboot request
// config channel: i_cfg_valid / o_cfg_ready with register index and data;
//   ready is always high, write only while no command is in flight
// path: an accepted command is held in the input register, its result is
//   computed there and loaded into the result register when that register
//   can take it; once loaded, the result word is valid at the output
// throughput: one command per cycle unless the output stalls; the bytewise
//   crc and counters are combinational between input and result registers
// stall: while the result register is full and stalled, the input register
//   holds its word and o_in_stall is high once that register is occupied
//   too; nothing is lost
// reset: synchronous active-low; the session goes idle with zero count,
//   zero crc, no error, reboot disarmed, reboot delay back to 200 ticks
module image_download_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  idc_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output idc_pkg::t_out_word  o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [idc_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    // configuration registers
    logic [idc_pkg::COUNT_BITS-1:0] r_exp_size;
    logic [31:0]                    r_exp_crc;
    logic [idc_pkg::DELAY_BITS-1:0] r_delay;

    // session state
    idc_pkg::t_status               r_status, n_status;
    idc_pkg::t_err                  r_err, n_err;
    logic [idc_pkg::COUNT_BITS-1:0] r_count, n_count;
    logic [31:0]                    r_crc, n_crc;
    logic                           r_armed, n_armed;
    logic [idc_pkg::DELAY_BITS-1:0] r_countdown, n_countdown;
    logic [idc_pkg::COUNT_BITS-1:0] r_held_size, n_held_size;
    logic [31:0]                    r_held_crc, n_held_crc;

    // pipeline registers
    logic                r_in_valid;
    idc_pkg::t_in_word   r_in;
    logic                r_out_valid;
    idc_pkg::t_out_word  r_out, n_out;

    logic n_ok, n_accepted, n_reboot;
    logic proc;

    // process the held word when the result register can take it
    assign proc        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !proc;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_size <= '0;
            r_exp_crc  <= '0;
            r_delay    <= idc_pkg::DELAY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (idc_pkg::t_cfg_idx'(i_cfg_index))
                idc_pkg::CFG_EXP_SIZE: r_exp_size <= i_cfg_data[idc_pkg::COUNT_BITS-1:0];
                idc_pkg::CFG_EXP_CRC:  r_exp_crc  <= i_cfg_data;
                idc_pkg::CFG_DELAY:    r_delay    <= i_cfg_data[idc_pkg::DELAY_BITS-1:0];
                default: ;
            endcase
        end
    end

    // next session state
    always_comb begin
        n_status    = r_status;
        n_err       = r_err;
        n_count     = r_count;
        n_crc       = r_crc;
        n_armed     = r_armed;
        n_countdown = r_countdown;
        n_held_size = r_held_size;
        n_held_crc  = r_held_crc;
        n_ok        = 1'b0;
        n_accepted  = 1'b0;
        n_reboot    = 1'b0;
        unique case (idc_pkg::t_func'(r_in.func))
            idc_pkg::FN_BEGIN: begin
                if (r_status == idc_pkg::ST_BUSY) begin
                    n_err = idc_pkg::E_ACTIVE;
                end else if (r_exp_size == '0) begin
                    n_err = idc_pkg::E_BADSIZE;
                end else if (!r_in.flash_ok) begin
                    n_err = idc_pkg::E_FLASH;
                end else begin
                    n_status    = idc_pkg::ST_BUSY;
                    n_err       = idc_pkg::E_NONE;
                    n_held_size = r_exp_size;
                    n_held_crc  = r_exp_crc;
                    n_count     = '0;
                    n_crc       = '0;
                    n_armed     = 1'b0;
                    n_countdown = '0;
                    n_ok        = 1'b1;
                end
            end
            idc_pkg::FN_DATA: begin
                if (r_status != idc_pkg::ST_BUSY) begin
                    n_err = idc_pkg::E_NOTSTARTED;
                end else if (r_count >= r_held_size) begin
                    // past the expected size: dropped silently
                    n_ok = 1'b1;
                end else if (!r_in.flash_ok) begin
                    n_err    = idc_pkg::E_FLASH;
                    n_status = idc_pkg::ST_FAIL;
                end else begin
                    n_count = r_count + 1'b1;
                    if (r_held_crc != '0) begin
                        n_crc = idc_pkg::crc_byte(r_crc, r_in.data_byte);
                    end
                    n_ok       = 1'b1;
                    n_accepted = 1'b1;
                end
            end
            idc_pkg::FN_END: begin
                if (r_status != idc_pkg::ST_BUSY) begin
                    n_err = idc_pkg::E_NOTACTIVE;
                end else if (r_count != r_held_size) begin
                    n_err    = idc_pkg::E_SIZE;
                    n_status = idc_pkg::ST_FAIL;
                end else if (r_held_crc != '0 && r_crc != r_held_crc) begin
                    n_err    = idc_pkg::E_CRC;
                    n_status = idc_pkg::ST_FAIL;
                end else if (!r_in.flash_ok) begin
                    n_err    = idc_pkg::E_FLASH;
                    n_status = idc_pkg::ST_FAIL;
                end else begin
                    n_status = idc_pkg::ST_DONE;
                    if (r_in.reboot_after) begin
                        n_armed     = 1'b1;
                        n_countdown = r_delay;
                    end
                    n_ok = 1'b1;
                end
            end
            idc_pkg::FN_ABORT: begin
                n_status    = idc_pkg::ST_IDLE;
                n_err       = idc_pkg::E_ABORTED;
                n_count     = '0;
                n_crc       = '0;
                n_armed     = 1'b0;
                n_countdown = '0;
                n_held_size = '0;
                n_held_crc  = '0;
            end
            idc_pkg::FN_TICK: begin
                if (r_armed) begin
                    if (r_countdown <= idc_pkg::DELAY_BITS'(1)) begin
                        n_armed     = 1'b0;
                        n_countdown = '0;
                        n_reboot    = 1'b1;
                    end else begin
                        n_countdown = r_countdown - 1'b1;
                    end
                end
                n_ok = 1'b1;
            end
            default: ;
        endcase
    end

    // result word from the state after the command
    always_comb begin
        n_out.ok             = n_ok;
        n_out.accepted       = n_accepted;
        n_out.status         = n_status;
        n_out.last_error     = n_err;
        n_out.bytes_written  = n_count;
        n_out.crc_value      = n_crc;
        n_out.reboot_request = n_reboot;
    end

    // session state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status    <= idc_pkg::ST_IDLE;
            r_err       <= idc_pkg::E_NONE;
            r_count     <= '0;
            r_crc       <= '0;
            r_armed     <= 1'b0;
            r_countdown <= '0;
            r_held_size <= '0;
            r_held_crc  <= '0;
        end else if (proc) begin
            r_status    <= n_status;
            r_err       <= n_err;
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_armed     <= n_armed;
            r_countdown <= n_countdown;
            r_held_size <= n_held_size;
            r_held_crc  <= n_held_crc;
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_word;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out <= n_out;
        end
    end

    // an armed reboot only exists after a successful end
    a_armed_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> r_status == idc_pkg::ST_DONE)
        else $error("reboot armed outside success status");

    // the byte count never passes the latched size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_held_size)
        else $error("byte count beyond latched size");

    // an accepted byte leaves the session in progress
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.accepted) |->
            (r_out.ok && r_out.status == idc_pkg::ST_BUSY))
        else $error("accepted byte without active session");

    // a word processed this cycle shows as a valid result next cycle
    a_proc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> r_out_valid)
        else $error("processed word lost");

    // a reboot request fires only on a tick that disarms the countdown
    a_reboot_disarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && n_reboot) |=> (!r_armed && r_out.ok))
        else $error("reboot request without disarm");

endmodule
